/* rtl/rct_pkg.sv */
`default_nettype none
package rct_pkg;

	localparam int ChanW    = 5;
	localparam int ColorW   = 3 * ChanW;
	localparam int ThirdQ16 = (1 << 16) / 3;
	localparam int ChanMax  = (1 << ChanW) - 1;

	// register index, taken from paddr[2]
	localparam logic RegTarget = 1'b0;
	localparam logic RegAmount = 1'b1;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [ColorW-1:0] color_t;
	typedef logic [5:0] amount_t;
	typedef logic signed [6:0] off_t;
	typedef logic signed [12:0] prod_t;

	typedef struct packed {
		off_t r;
		off_t g;
		off_t b;
	} tgt_off_t;

	typedef struct packed {
		logic [3:1] valid;
		logic [3:1] adv;
	} pipe_status_t;

	// about a third of the channel sum, rounded down
	function automatic chan_t grey_level(chan_t r, chan_t g, chan_t b);
		logic [6:0]  s;
		logic [21:0] p;
		s = {2'b00, r} + {2'b00, g} + {2'b00, b};
		p = {15'b0, s} * 22'(ThirdQ16);
		return p[20:16];
	endfunction

	function automatic off_t chan_offset(chan_t c, chan_t lev);
		return $signed({2'b00, c}) - $signed({2'b00, lev});
	endfunction

	function automatic chan_t clamp_chan(logic signed [9:0] v);
		chan_t res;
		if (v < 0) begin
			res = '0;
		end else if (v > 10'sd31) begin
			res = chan_t'(ChanMax);
		end else begin
			res = v[ChanW-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/rct_regs.sv */
`default_nettype none
module rct_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output rct_pkg::tgt_off_t      tgt_off,
	output rct_pkg::amount_t       amount
);

	rct_pkg::color_t  target_color_q;
	rct_pkg::amount_t blend_amount_q;
	rct_pkg::chan_t   tr, tg, tb, tlev;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_color_q <= '0;
			blend_amount_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				rct_pkg::RegTarget: target_color_q <= pwdata[rct_pkg::ColorW-1:0];
				rct_pkg::RegAmount: blend_amount_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rct_pkg::RegTarget: prdata = {17'b0, target_color_q};
			rct_pkg::RegAmount: prdata = {26'b0, blend_amount_q};
			default:            prdata = '0;
		endcase
	end

	// target offsets are static between writes
	assign tr   = target_color_q[14:10];
	assign tg   = target_color_q[9:5];
	assign tb   = target_color_q[4:0];
	assign tlev = rct_pkg::grey_level(tr, tg, tb);

	assign tgt_off.r = rct_pkg::chan_offset(tr, tlev);
	assign tgt_off.g = rct_pkg::chan_offset(tg, tlev);
	assign tgt_off.b = rct_pkg::chan_offset(tb, tlev);
	assign amount    = blend_amount_q;

endmodule
`default_nettype wire

/* rtl/rct_pipe.sv */
`default_nettype none
module rct_pipe (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,  // [14:0] color_in, [15] ignored
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [15:0]          m_tdata,  // [14:0] color_out, [15] zero
	input  wire rct_pkg::tgt_off_t    tgt_off,
	input  wire rct_pkg::amount_t     amount,
	output rct_pkg::pipe_status_t     status
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	rct_pkg::chan_t  ch_s1 [3];
	rct_pkg::chan_t  lev_s1;
	rct_pkg::chan_t  lev_s2;
	rct_pkg::off_t   off_s2 [3];
	rct_pkg::prod_t  prod_s2 [3];
	rct_pkg::color_t color_s3;

	rct_pkg::chan_t  ch_in [3];
	rct_pkg::off_t   tgt_a [3];
	rct_pkg::chan_t  new_ch [3];

	// each stage moves when the next one is empty or moving
	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	assign tgt_a[0] = tgt_off.b;
	assign tgt_a[1] = tgt_off.g;
	assign tgt_a[2] = tgt_off.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rct_pkg::off_t             off_c;
		logic signed [7:0]         diff;
		logic signed [14:0]        prod_full;
		logic signed [7:0]         step;
		logic signed [9:0]         rebuilt;

		assign ch_in[i] = s_tdata[i*rct_pkg::ChanW +: rct_pkg::ChanW];

		// stage 2 math: offset from level, blend product
		assign off_c     = rct_pkg::chan_offset(ch_s1[i], lev_s1);
		assign diff      = 8'(tgt_a[i]) - 8'(off_c);
		assign prod_full = 15'(diff) * $signed({1'b0, amount});

		// stage 3 math: floor shift, rebuild, clamp
		assign step      = prod_s2[i][12:5];
		assign rebuilt   = 10'(off_s2[i]) + 10'(step) + $signed({5'b0, lev_s2});
		assign new_ch[i] = rct_pkg::clamp_chan(rebuilt);

		always_ff @(posedge clk) begin
			if (adv1 && s_tvalid) begin
				ch_s1[i] <= ch_in[i];
			end
			if (adv2 && v_s1) begin
				off_s2[i]  <= off_c;
				prod_s2[i] <= prod_full[12:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			lev_s1 <= rct_pkg::grey_level(ch_in[2], ch_in[1], ch_in[0]);
		end
		if (adv2 && v_s1) begin
			lev_s2 <= lev_s1;
		end
		if (adv3 && v_s2) begin
			color_s3 <= {new_ch[2], new_ch[1], new_ch[0]};
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {1'b0, color_s3};

	assign status.valid = {v_s3, v_s2, v_s1};
	assign status.adv   = {adv3, adv2, adv1};

endmodule
`default_nettype wire

/* rtl/rgb555_colorize_tint.sv */
// an accepted request is registered in stage 1, stage 2 and stage 3 in turn before its result shows on m_tvalid
// throughput: one color per cycle while the output is not stalled, three register stages (level, blend product, clamp)
// a stalled output holds its stage; earlier stages keep filling until they are full
// reset (arst_n low) empties the pipeline and clears target_color and blend_amount to 0
`default_nettype none
module rgb555_colorize_tint (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [14:0] color_in, [15] unused
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,  // [14:0] color_out, [15] zero
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	rct_pkg::tgt_off_t     tgt_off;
	rct_pkg::amount_t      amount;
	rct_pkg::pipe_status_t status;

	rct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tgt_off (tgt_off),
		.amount  (amount)
	);

	rct_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.tgt_off  (tgt_off),
		.amount   (amount),
		.status   (status)
	);

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output stage");

	// a held stage keeps its request
	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid[1] && !status.adv[2]) |=> status.valid[1])
		else $error("stage 1 request lost during stall");

	// result taken with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !status.valid[2]) |=> !m_tvalid)
		else $error("result repeated after drain");

endmodule
`default_nettype wire
